/* src/tamq_pkg.sv */
// shared types, constants and helpers for the two-axis motor encoder model
`timescale 1ns / 1ps

package tamq_pkg;

    localparam int POSITION_BITS = 10;
    localparam int TIMER_BITS    = 16;
    localparam int ENCODER_BITS  = 2;
    localparam int DIR_BITS      = 2;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam int IN_DATA_BITS   = 8;
    localparam int OUT_FIELD_BITS = 2 * POSITION_BITS + 2 * ENCODER_BITS + 2;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

    localparam logic [TIMER_BITS-1:0]    STEP_PERIOD_RESET = TIMER_BITS'(2500);
    localparam logic [POSITION_BITS-1:0] X_LIMIT_RESET     = POSITION_BITS'(750 - 1);
    localparam logic [POSITION_BITS-1:0] Y_LIMIT_RESET     = POSITION_BITS'(575 - 1);
    localparam logic [POSITION_BITS-1:0] X_POSITION_RESET  = POSITION_BITS'(139);
    localparam logic [POSITION_BITS-1:0] Y_POSITION_RESET  = POSITION_BITS'(522);
    localparam logic [TIMER_BITS-1:0]    REMAINING_RESET   = TIMER_BITS'(2500 / 2);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_STEP_PERIOD = 2'd0,
        REG_X_LIMIT     = 2'd1,
        REG_Y_LIMIT     = 2'd2
    } reg_index_t;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_WRITE = 1'b1
    } operation_t;

    // direction bit 1 = increase, bit 0 = decrease
    localparam logic [DIR_BITS-1:0] DIR_STOP = 2'b00;
    localparam logic [DIR_BITS-1:0] DIR_BOTH = 2'b11;
    localparam int DIR_UP_BIT = 1;

    typedef struct packed {
        logic [DIR_BITS-1:0]      direction;
        logic [POSITION_BITS-1:0] position;
        logic [TIMER_BITS-1:0]    remaining;
        logic [ENCODER_BITS-1:0]  encoder;
        logic                     running;
    } axis_state_t;

    function automatic logic [ENCODER_BITS-1:0] gray_code(input logic [1:0] low_bits);
        logic [ENCODER_BITS-1:0] code;
        begin
            case (low_bits)
                2'd0:    code = 2'd0;
                2'd1:    code = 2'd1;
                2'd2:    code = 2'd3;
                2'd3:    code = 2'd2;
                default: code = 2'd0;
            endcase
            return code;
        end
    endfunction

endpackage

/* src/tamq_axis.sv */
// next-state logic for one motor axis: countdown, stepping and direction control
`timescale 1ns / 1ps

module tamq_axis
(
    input  tamq_pkg::axis_state_t                cur,
    input  logic                                 operation,
    input  logic [tamq_pkg::DIR_BITS-1:0]        dir_in,
    input  logic [tamq_pkg::TIMER_BITS-1:0]      step_period,
    input  logic [tamq_pkg::POSITION_BITS-1:0]   limit,
    output tamq_pkg::axis_state_t                nxt
);
    import tamq_pkg::*;

    logic [DIR_BITS-1:0]      dir_clean;
    logic                     can_step;
    logic [POSITION_BITS-1:0] stepped_position;

    assign dir_clean = (dir_in == DIR_BOTH) ? DIR_STOP : dir_in;

    always_comb
    begin
        if (cur.direction[DIR_UP_BIT])
        begin
            can_step         = cur.position < limit;
            stepped_position = cur.position + POSITION_BITS'(1);
        end
        else
        begin
            can_step         = cur.position != '0;
            stepped_position = cur.position - POSITION_BITS'(1);
        end
    end

    always_comb
    begin
        nxt = cur;
        if (operation == OP_WRITE)
        begin
            if (dir_clean != cur.direction)
            begin
                // phase flip when the increase bit changes
                if (dir_clean[DIR_UP_BIT] != cur.direction[DIR_UP_BIT])
                begin
                    nxt.remaining = (cur.remaining > step_period) ? '0
                                    : step_period - cur.remaining;
                end
                nxt.direction = dir_clean;
                nxt.running   = dir_clean != DIR_STOP;
            end
        end
        else if (cur.running)
        begin
            if (cur.remaining > TIMER_BITS'(1))
            begin
                nxt.remaining = cur.remaining - TIMER_BITS'(1);
            end
            else
            begin
                nxt.remaining = step_period;
                if (can_step)
                begin
                    nxt.position = stepped_position;
                    nxt.encoder  = gray_code(stepped_position[1:0]);
                end
                else
                begin
                    nxt.running = 1'b0;
                end
            end
        end
    end

endmodule

/* src/two_axis_motor_quadrature_sim.sv */
// top level: two motor axes with quadrature encoders, config port and output stage
// the result of an accepted item is registered in the output register, or in the skid entry while the output is held
// throughput: one item per cycle while the skid entry is empty; both axes update from one compare and add each
// a two-entry output stage keeps s_tready registered, independent of m_tready
// reset: asynchronous active-low; registers at their defaults, positions 139 and 522,
// both axes stopped, countdown at half of the default period, no result pending
`timescale 1ns / 1ps

module two_axis_motor_quadrature_sim
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [tamq_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [tamq_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [tamq_pkg::IN_DATA_BITS-1:0]      s_tdata,  // control_byte
    input  logic                                   s_tuser,  // operation
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // x_position, y_position, x_encoder, y_encoder, x_moving, y_moving, zero fill
    output logic [tamq_pkg::OUT_DATA_BITS-1:0]     m_tdata
);
    import tamq_pkg::*;

    logic [TIMER_BITS-1:0]    step_period_reg;
    logic [POSITION_BITS-1:0] x_limit_reg;
    logic [POSITION_BITS-1:0] y_limit_reg;

    axis_state_t x_state_reg, x_state_next, x_state_calc;
    axis_state_t y_state_reg, y_state_next, y_state_calc;

    logic [OUT_DATA_BITS-1:0] out_data_reg, out_data_next, result;
    logic [OUT_DATA_BITS-1:0] skid_data_reg, skid_data_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     skid_valid_reg, skid_valid_next;

    logic accept;
    logic take;

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign accept    = s_tvalid && s_tready;
    assign take      = out_valid_reg && m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_period_reg <= STEP_PERIOD_RESET;
            x_limit_reg     <= X_LIMIT_RESET;
            y_limit_reg     <= Y_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_STEP_PERIOD: step_period_reg <= cfg_data[TIMER_BITS-1:0];
                REG_X_LIMIT:     x_limit_reg     <= cfg_data[POSITION_BITS-1:0];
                REG_Y_LIMIT:     y_limit_reg     <= cfg_data[POSITION_BITS-1:0];
                default:         ;
            endcase
        end
    end

    // x: d3 right (increase), d2 left (decrease)
    tamq_axis u_axis_x
    (
        .cur         (x_state_reg),
        .operation   (s_tuser),
        .dir_in      ({s_tdata[3], s_tdata[2]}),
        .step_period (step_period_reg),
        .limit       (x_limit_reg),
        .nxt         (x_state_calc)
    );

    // y: d0 down (increase), d1 up (decrease)
    tamq_axis u_axis_y
    (
        .cur         (y_state_reg),
        .operation   (s_tuser),
        .dir_in      ({s_tdata[0], s_tdata[1]}),
        .step_period (step_period_reg),
        .limit       (y_limit_reg),
        .nxt         (y_state_calc)
    );

    assign x_state_next = accept ? x_state_calc : x_state_reg;
    assign y_state_next = accept ? y_state_calc : y_state_reg;

    assign result = OUT_DATA_BITS'({y_state_calc.running, x_state_calc.running,
                                    y_state_calc.encoder, x_state_calc.encoder,
                                    y_state_calc.position, x_state_calc.position});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_state_reg <= '{direction: DIR_STOP, position: X_POSITION_RESET,
                             remaining: REMAINING_RESET, encoder: '0, running: 1'b0};
            y_state_reg <= '{direction: DIR_STOP, position: Y_POSITION_RESET,
                             remaining: REMAINING_RESET, encoder: '0, running: 1'b0};
        end
        else
        begin
            x_state_reg <= x_state_next;
            y_state_reg <= y_state_next;
        end
    end

    // output register plus skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (!out_valid_reg || take)
            begin
                out_data_next  = result;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = result;
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    // a held skid entry always sits behind a pending output transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without pending output");

    // axis state only moves on an accepted item
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(accept) |-> ($stable(x_state_reg) && $stable(y_state_reg)))
        else $error("axis state changed without an accepted item");

    // a running axis always has a direction
    assert property (@(posedge clk) disable iff (!rst_n)
        (!x_state_reg.running || x_state_reg.direction != DIR_STOP) &&
        (!y_state_reg.running || y_state_reg.direction != DIR_STOP))
        else $error("axis running with no direction");

    // a step moves the x position by one count at most
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(accept) && ($past(x_state_reg.position) != x_state_reg.position) |->
        ((x_state_reg.position == $past(x_state_reg.position) + POSITION_BITS'(1)) ||
         (x_state_reg.position == $past(x_state_reg.position) - POSITION_BITS'(1))))
        else $error("x position jumped by more than one count");

endmodule
